>>> rtl/core/tgapd_pkg.sv
// Package for the TGA true-colour pixel decoder.
// Holds the parse phases, result status codes, depth codes and the job type
// passed from the front parser to the back formatter. No dependencies.
package tgapd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_IDSKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_BAD_MAP   = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_BAD_DEPTH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        DEPTH_15,
        DEPTH_16,
        DEPTH_24,
        DEPTH_32
    } t_depth;

    localparam logic [7:0] BPP_15        = 8'd15;
    localparam logic [7:0] BPP_16        = 8'd16;
    localparam logic [7:0] BPP_24        = 8'd24;
    localparam logic [7:0] BPP_32        = 8'd32;
    localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR   = 8'h00;

    typedef struct packed {
        t_status     status;
        t_depth      depth;
        logic [31:0] raw;
        logic [15:0] row;
        logic [15:0] col;
        logic        last;
    } t_job;

endpackage

>>> rtl/core/tgapd_front.sv
// Front parser of the TGA decoder: header, ID skip and pixel byte assembly.
// Emits one job per finished pixel or header error into the job queue.
// Depends on tgapd_pkg.
module tgapd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_file_start,
    input  logic            i_full,
    output logic            o_stall,
    output logic            o_push,
    output tgapd_pkg::t_job o_job
);
    import tgapd_pkg::*;

    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HGT_LO   = 5'd14;
    localparam logic [4:0] HDR_HGT_HI   = 5'd15;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_DESCR    = 5'd17;

    t_phase      r_phase, n_phase, e_phase;
    logic [4:0]  r_idx, n_idx, e_idx;
    logic [7:0]  r_id, n_id, e_id;
    logic [7:0]  r_map, n_map, e_map;
    logic [7:0]  r_kind, n_kind, e_kind;
    logic [15:0] r_width, n_width, e_width;
    logic [15:0] r_height, n_height, e_height;
    logic [7:0]  r_bpp, n_bpp, e_bpp;
    logic [23:0] r_pix, n_pix, e_pix;
    logic [1:0]  r_bip, n_bip, e_bip;
    logic [15:0] r_row, n_row, e_row;
    logic [15:0] r_col, n_col, e_col;

    logic        accept;
    logic        empty_img;
    logic        depth_ok;
    t_status     hdr_status;
    t_depth      depth;
    logic [1:0]  last_byte;
    logic        pix_done;
    logic        is_last;
    logic        row_end;
    logic [16:0] row_inc;
    logic [16:0] col_inc;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    assign e_phase  = i_file_start ? PH_HEADER : r_phase;
    assign e_idx    = i_file_start ? '0 : r_idx;
    assign e_id     = i_file_start ? '0 : r_id;
    assign e_map    = i_file_start ? '0 : r_map;
    assign e_kind   = i_file_start ? '0 : r_kind;
    assign e_width  = i_file_start ? '0 : r_width;
    assign e_height = i_file_start ? '0 : r_height;
    assign e_bpp    = i_file_start ? '0 : r_bpp;
    assign e_pix    = i_file_start ? '0 : r_pix;
    assign e_bip    = i_file_start ? '0 : r_bip;
    assign e_row    = i_file_start ? '0 : r_row;
    assign e_col    = i_file_start ? '0 : r_col;

    assign empty_img = (e_width == '0) || (e_height == '0);
    assign depth_ok  = (e_bpp == BPP_15) || (e_bpp == BPP_16) ||
                       (e_bpp == BPP_24) || (e_bpp == BPP_32);

    always_comb begin
        if (e_map != '0) begin
            hdr_status = ST_BAD_MAP;
        end else if (e_kind != IMG_TRUECOLOR) begin
            hdr_status = ST_BAD_TYPE;
        end else if (!depth_ok) begin
            hdr_status = ST_BAD_DEPTH;
        end else begin
            hdr_status = ST_PIXEL;
        end
    end

    always_comb begin
        if (e_bpp == BPP_15) begin
            depth     = DEPTH_15;
            last_byte = 2'd1;
        end else if (e_bpp == BPP_16) begin
            depth     = DEPTH_16;
            last_byte = 2'd1;
        end else if (e_bpp == BPP_24) begin
            depth     = DEPTH_24;
            last_byte = 2'd2;
        end else begin
            depth     = DEPTH_32;
            last_byte = 2'd3;
        end
    end

    assign pix_done = (e_bip >= last_byte);
    assign row_inc  = {1'b0, e_row} + 17'd1;
    assign col_inc  = {1'b0, e_col} + 17'd1;
    assign is_last  = (row_inc == {1'b0, e_height}) && (col_inc == {1'b0, e_width});
    assign row_end  = (col_inc >= {1'b0, e_width});

    // next phase
    always_comb begin
        n_phase = e_phase;
        unique case (e_phase)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_HEADER: begin
                if (e_idx == HDR_DESCR) begin
                    if (hdr_status != ST_PIXEL) begin
                        n_phase = PH_DONE;
                    end else if (e_id != '0) begin
                        n_phase = PH_IDSKIP;
                    end else begin
                        n_phase = empty_img ? PH_DONE : PH_PIXELS;
                    end
                end
            end
            PH_IDSKIP: begin
                if (e_id == 8'd1) begin
                    n_phase = empty_img ? PH_DONE : PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (pix_done && is_last) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // datapath and job outputs
    always_comb begin
        n_idx    = e_idx;
        n_id     = e_id;
        n_map    = e_map;
        n_kind   = e_kind;
        n_width  = e_width;
        n_height = e_height;
        n_bpp    = e_bpp;
        n_pix    = e_pix;
        n_bip    = e_bip;
        n_row    = e_row;
        n_col    = e_col;
        o_push   = 1'b0;
        o_job    = '0;
        unique case (e_phase)
            PH_HEADER: begin
                case (e_idx)
                    HDR_ID_LEN:   n_id = i_data_byte;
                    HDR_MAP_TYPE: n_map = i_data_byte;
                    HDR_IMG_TYPE: n_kind = i_data_byte;
                    HDR_WIDTH_LO: n_width = {e_width[15:8], i_data_byte};
                    HDR_WIDTH_HI: n_width = {i_data_byte, e_width[7:0]};
                    HDR_HGT_LO:   n_height = {e_height[15:8], i_data_byte};
                    HDR_HGT_HI:   n_height = {i_data_byte, e_height[7:0]};
                    HDR_DEPTH:    n_bpp = i_data_byte;
                    default:      n_idx = e_idx;
                endcase
                if (e_idx < HDR_DESCR) begin
                    n_idx = e_idx + 5'd1;
                end else if (hdr_status != ST_PIXEL) begin
                    o_push       = accept;
                    o_job.status = hdr_status;
                end
            end
            PH_IDSKIP: begin
                n_id = e_id - 8'd1;
            end
            PH_PIXELS: begin
                if (!pix_done) begin
                    case (e_bip)
                        2'd0:    n_pix[7:0]   = i_data_byte;
                        2'd1:    n_pix[15:8]  = i_data_byte;
                        default: n_pix[23:16] = i_data_byte;
                    endcase
                    n_bip = e_bip + 2'd1;
                end else begin
                    o_push       = accept;
                    o_job.status = ST_PIXEL;
                    o_job.depth  = depth;
                    o_job.row    = e_row;
                    o_job.col    = e_col;
                    o_job.last   = is_last;
                    case (last_byte)
                        2'd1:    o_job.raw = {16'h0000, i_data_byte, e_pix[7:0]};
                        2'd2:    o_job.raw = {8'h00, i_data_byte, e_pix[15:0]};
                        default: o_job.raw = {i_data_byte, e_pix};
                    endcase
                    n_pix = '0;
                    n_bip = '0;
                    if (!is_last) begin
                        if (row_end) begin
                            n_col = '0;
                            n_row = e_row + 16'd1;
                        end else begin
                            n_col = e_col + 16'd1;
                        end
                    end
                end
            end
            default: begin
                n_idx = e_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_idx    <= '0;
            r_id     <= '0;
            r_map    <= '0;
            r_kind   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bpp    <= '0;
            r_pix    <= '0;
            r_bip    <= '0;
            r_row    <= '0;
            r_col    <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_id     <= n_id;
            r_map    <= n_map;
            r_kind   <= n_kind;
            r_width  <= n_width;
            r_height <= n_height;
            r_bpp    <= n_bpp;
            r_pix    <= n_pix;
            r_bip    <= n_bip;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

endmodule

>>> rtl/core/tgapd_queue.sv
// Two-entry job queue between the front parser and the back formatter.
// Push and pop may occur in the same cycle. Depends on tgapd_pkg.
module tgapd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tgapd_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tgapd_pkg::t_job o_job
);
    import tgapd_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/core/tgapd_back.sv
// Back formatter of the TGA decoder: splits a queued job into RGBA channels
// and holds the result in the output register. Depends on tgapd_pkg.
module tgapd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  tgapd_pkg::t_job i_job,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha,
    output logic [15:0]     o_pixel_row,
    output logic [15:0]     o_pixel_column,
    output logic            o_last_pixel,
    output logic [1:0]      o_status
);
    import tgapd_pkg::*;

    logic        r_valid, n_valid;
    logic [7:0]  r_red, r_green, r_blue, r_alpha;
    logic [15:0] r_row, r_col;
    logic        r_last;
    t_status     r_status;
    logic [7:0]  n_red, n_green, n_blue, n_alpha;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_alpha = '0;
        if (i_job.status == ST_PIXEL) begin
            unique case (i_job.depth) inside
                DEPTH_15, DEPTH_16: begin
                    n_red   = {3'b000, i_job.raw[14:10]};
                    n_green = {3'b000, i_job.raw[9:5]};
                    n_blue  = {3'b000, i_job.raw[4:0]};
                    if (i_job.depth == DEPTH_15 || i_job.raw[15]) begin
                        n_alpha = ALPHA_OPAQUE;
                    end else begin
                        n_alpha = ALPHA_CLEAR;
                    end
                end
                DEPTH_24: begin
                    n_blue  = i_job.raw[7:0];
                    n_green = i_job.raw[15:8];
                    n_red   = i_job.raw[23:16];
                    n_alpha = ALPHA_OPAQUE;
                end
                default: begin
                    n_blue  = i_job.raw[7:0];
                    n_green = i_job.raw[15:8];
                    n_red   = i_job.raw[23:16];
                    n_alpha = i_job.raw[31:24];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_alpha  <= n_alpha;
            r_row    <= i_job.row;
            r_col    <= i_job.col;
            r_last   <= i_job.last;
            r_status <= i_job.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid        = r_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_alpha        = r_alpha;
    assign o_pixel_row    = r_row;
    assign o_pixel_column = r_col;
    assign o_last_pixel   = r_last;
    assign o_status       = r_status;

endmodule

>>> rtl/core/tga_truecolor_pixel_decoder_core.sv
// Top level of the TGA true-colour pixel decoder.
// Joins tgapd_front, tgapd_queue and tgapd_back. Depends on tgapd_pkg.
//
// Input channel: one file byte per item on i_data_byte, with i_file_start
// high on header byte 0 of each file. An item is taken at a clock edge with
// i_valid high and o_stall low.
// Output channel: one result per pixel (status 0) with R, G, B, A, row,
// column and last-pixel flag, or a single error result (status 1 to 3)
// after header byte 17. Taken at an edge with o_valid high and i_stall low.
// Throughput: one byte per cycle while o_stall is low. The byte that completes
// a result sends its job first into the job queue and then into the output
// register.
// o_stall rises only when the two-entry job queue is full, which happens when
// the receiver holds i_stall with two results waiting behind the output
// register; the held result keeps its value until taken.
// Reset clears the parser to idle, empties the queue and drops o_valid; bytes
// are ignored until one arrives with i_file_start set.
module tga_truecolor_pixel_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [15:0] o_pixel_row,
    output logic [15:0] o_pixel_column,
    output logic        o_last_pixel,
    output logic [1:0]  o_status
);
    import tgapd_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job head_job;

    tgapd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_job        (front_job)
    );

    tgapd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    tgapd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (head_job),
        .i_stall        (i_stall),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_column (o_pixel_column),
        .o_last_pixel   (o_last_pixel),
        .o_status       (o_status)
    );

endmodule

>>> rtl/core/tgapd_checker.sv
// Port-level checks for the TGA decoder top level, bound to it below.
// Depends on tgapd_pkg.
module tgapd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_alpha,
    input logic [15:0] o_pixel_row,
    input logic [15:0] o_pixel_column,
    input logic        o_last_pixel,
    input logic [1:0]  o_status
);
    import tgapd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_alpha) &&
                               $stable(o_pixel_row) && $stable(o_status))
        else $error("held result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_PIXEL) |->
            o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0 &&
            o_pixel_row == 16'd0 && o_pixel_column == 16'd0 && !o_last_pixel)
        else $error("error result carries pixel data");

endmodule

bind tga_truecolor_pixel_decoder_core tgapd_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_red          (o_red),
    .o_green        (o_green),
    .o_blue         (o_blue),
    .o_alpha        (o_alpha),
    .o_pixel_row    (o_pixel_row),
    .o_pixel_column (o_pixel_column),
    .o_last_pixel   (o_last_pixel),
    .o_status       (o_status)
);
